// ----- rtl/mccc_pkg.sv -----
// Package for the millisecond calendar clock: field widths, the time
// record type, carry limits and reset values. No dependencies.
`default_nettype none

package mccc_pkg;

  localparam int unsigned MS_W     = 10;
  localparam int unsigned SEC_W    = 6;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned YEAR_W   = 16;

  // Item kinds
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  // Top values: a field at or above its top wraps and carries
  localparam logic [MS_W-1:0]     MS_TOP     = 10'd999;
  localparam logic [SEC_W-1:0]    SEC_TOP    = 6'd59;
  localparam logic [MINUTE_W-1:0] MINUTE_TOP = 6'd59;
  localparam logic [HOUR_W-1:0]   HOUR_TOP   = 5'd23;
  localparam logic [MONTH_W-1:0]  MONTH_TOP  = 4'd12;

  localparam logic [DAY_W-1:0]    DAY_FIRST   = 5'd1;
  localparam logic [MONTH_W-1:0]  MONTH_FIRST = 4'd1;

  localparam logic [DAY_W-1:0] DAYS_LONG  = 5'd31;
  localparam logic [DAY_W-1:0] DAYS_SHORT = 5'd30;
  localparam logic [DAY_W-1:0] DAYS_LEAP  = 5'd29;
  localparam logic [DAY_W-1:0] DAYS_FEB   = 5'd28;
  localparam logic [DAY_W-1:0] DAYS_NONE  = 5'd0;

  // Inverse of 25 modulo 2^16, and the largest multiple quotient:
  // y is divisible by 25 exactly when (y * INV25) mod 2^16 <= DIV25_MAX
  localparam logic [YEAR_W-1:0] INV25     = 16'd23593;
  localparam logic [YEAR_W-1:0] DIV25_MAX = 16'd2621;

  localparam logic [YEAR_W-1:0] YEAR_RESET = 16'd2015;

  typedef struct packed {
    logic [MS_W-1:0]     ms;
    logic [SEC_W-1:0]    sec;
    logic [MINUTE_W-1:0] minute;
    logic [HOUR_W-1:0]   hour;
    logic [DAY_W-1:0]    day;
    logic [MONTH_W-1:0]  month;
    logic [YEAR_W-1:0]   year;
  } time_t;

endpackage

`default_nettype wire

// ----- rtl/mccc_if.sv -----
// Handshake channels of the millisecond calendar clock: request and result.
// Depends on mccc_pkg for the field widths.
`default_nettype none

interface mccc_req_if
  import mccc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                command;
  logic [MS_W-1:0]     set_ms;
  logic [SEC_W-1:0]    set_sec;
  logic [MINUTE_W-1:0] set_minute;
  logic [HOUR_W-1:0]   set_hour;
  logic [DAY_W-1:0]    set_day;
  logic [MONTH_W-1:0]  set_month;
  logic [YEAR_W-1:0]   set_year;

  modport source (
    output valid, command, set_ms, set_sec, set_minute, set_hour, set_day,
           set_month, set_year,
    input  ready
  );
  modport sink (
    input  valid, command, set_ms, set_sec, set_minute, set_hour, set_day,
           set_month, set_year,
    output ready
  );
endinterface

interface mccc_res_if
  import mccc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [MS_W-1:0]     now_ms;
  logic [SEC_W-1:0]    now_sec;
  logic [MINUTE_W-1:0] now_minute;
  logic [HOUR_W-1:0]   now_hour;
  logic [DAY_W-1:0]    now_day;
  logic [MONTH_W-1:0]  now_month;
  logic [YEAR_W-1:0]   now_year;

  modport source (
    output valid, now_ms, now_sec, now_minute, now_hour, now_day, now_month,
           now_year,
    input  ready
  );
  modport sink (
    input  valid, now_ms, now_sec, now_minute, now_hour, now_day, now_month,
           now_year,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/mccc_step.sv -----
// Next-time logic: one millisecond carry cascade or a full load.
// Depends on mccc_pkg.
`default_nettype none

module mccc_step
  import mccc_pkg::*;
(
  input  time_t cur,
  input  logic  command,
  input  time_t load_val,
  output time_t nxt
);

  logic [YEAR_W-1:0] year_scaled;
  logic              div25;
  logic              leap;
  logic [DAY_W-1:0]  month_len;
  logic              c_ms, c_sec, c_minute, c_hour, c_day, c_month;
  time_t             tick;

  // Divisible by 100: by 4 and by 25. By 400: by 16 and by 25.
  assign year_scaled = 16'(cur.year * INV25);
  assign div25       = (year_scaled <= DIV25_MAX);
  assign leap        = (cur.year[1:0] == 2'd0) && (!div25 || (cur.year[3:0] == 4'd0));

  always_comb begin
    case (cur.month) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = DAYS_LONG;
      4'd4, 4'd6, 4'd9, 4'd11:                    month_len = DAYS_SHORT;
      4'd2:    month_len = leap ? DAYS_LEAP : DAYS_FEB;
      default: month_len = DAYS_NONE;
    endcase
  end

  assign c_ms     = (cur.ms >= MS_TOP);
  assign c_sec    = c_ms && (cur.sec >= SEC_TOP);
  assign c_minute = c_sec && (cur.minute >= MINUTE_TOP);
  assign c_hour   = c_minute && (cur.hour >= HOUR_TOP);
  assign c_day    = c_hour && (cur.day >= month_len);
  assign c_month  = c_day && (cur.month >= MONTH_TOP);

  always_comb begin
    tick = cur;
    tick.ms = c_ms ? '0 : cur.ms + 1'b1;
    if (c_ms) begin
      tick.sec = c_sec ? '0 : cur.sec + 1'b1;
    end
    if (c_sec) begin
      tick.minute = c_minute ? '0 : cur.minute + 1'b1;
    end
    if (c_minute) begin
      tick.hour = c_hour ? '0 : cur.hour + 1'b1;
    end
    if (c_hour) begin
      tick.day = c_day ? DAY_FIRST : cur.day + 1'b1;
    end
    if (c_day) begin
      tick.month = c_month ? MONTH_FIRST : cur.month + 1'b1;
    end
    if (c_month) begin
      tick.year = cur.year + 1'b1;
    end
  end

  assign nxt = (command == CMD_LOAD) ? load_val : tick;

endmodule

`default_nettype wire

// ----- rtl/millisecond_calendar_clock_core.sv -----
// Millisecond calendar clock, top level; uses mccc_pkg, mccc_if and mccc_step.
// An accepted request is held in the request stage; its result is registered in
// the result stage and taken from there. Throughput: one request per cycle;
// request.ready drops only while a full request stage faces a stalled result.
// Synchronous reset clears both stages and sets the time to 0 ms 0 s 0 min
// 0 h, day 0, month 0, year 2015.
`default_nettype none

module millisecond_calendar_clock_core
  import mccc_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  mccc_req_if.sink    request,
  mccc_res_if.source  result
);

  logic  req_valid;
  logic  req_command;
  time_t req_val;
  logic  req_advance;
  time_t cur_time;
  time_t nxt_time;
  logic  res_valid;
  time_t res_val;

  assign req_advance   = req_valid && (!res_valid || result.ready);
  assign request.ready = !req_valid || req_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (request.ready) begin
      req_valid <= request.valid;
    end
  end

  // Hold the request fields while the request stage is stalled
  always_ff @(posedge clk) begin
    if (request.ready && request.valid) begin
      req_command    <= request.command;
      req_val.ms     <= request.set_ms;
      req_val.sec    <= request.set_sec;
      req_val.minute <= request.set_minute;
      req_val.hour   <= request.set_hour;
      req_val.day    <= request.set_day;
      req_val.month  <= request.set_month;
      req_val.year   <= request.set_year;
    end
  end

  mccc_step u_step (
    .cur      (cur_time),
    .command  (req_command),
    .load_val (req_val),
    .nxt      (nxt_time)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_time  <= '{ms: '0, sec: '0, minute: '0, hour: '0, day: '0, month: '0,
                     year: YEAR_RESET};
      res_valid <= 1'b0;
    end else begin
      if (req_advance) begin
        cur_time <= nxt_time;
      end
      if (req_advance) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_advance) begin
      res_val <= nxt_time;
    end
  end

  assign result.valid      = res_valid;
  assign result.now_ms     = res_val.ms;
  assign result.now_sec    = res_val.sec;
  assign result.now_minute = res_val.minute;
  assign result.now_hour   = res_val.hour;
  assign result.now_day    = res_val.day;
  assign result.now_month  = res_val.month;
  assign result.now_year   = res_val.year;

endmodule

`default_nettype wire

// ----- rtl/mccc_checker.sv -----
// Port-level checks for the millisecond calendar clock, bound to the top level.
// Depends on mccc_pkg and millisecond_calendar_clock_core.
`default_nettype none

module mccc_checker
  import mccc_pkg::*;
(
  input wire                clk,
  input wire                rst,
  input wire                req_valid,
  input wire                req_ready,
  input wire                res_valid,
  input wire                res_ready,
  input wire [MS_W-1:0]     res_ms,
  input wire [SEC_W-1:0]    res_sec,
  input wire [MINUTE_W-1:0] res_minute,
  input wire [HOUR_W-1:0]   res_hour,
  input wire [DAY_W-1:0]    res_day,
  input wire [MONTH_W-1:0]  res_month,
  input wire [YEAR_W-1:0]   res_year
);

  // No result survives reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_ms) && $stable(res_sec)
      && $stable(res_minute) && $stable(res_hour) && $stable(res_day)
      && $stable(res_month) && $stable(res_year))
    else $error("stalled result changed");

  // A fresh result comes from a request taken earlier through the request stage
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(req_valid && req_ready, 2))
    else $error("result without an earlier request");

  // Back-pressure only from a stalled result
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> res_valid && !res_ready)
    else $error("request stalled with a free result stage");

endmodule

bind millisecond_calendar_clock_core mccc_checker u_mccc_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (request.valid),
  .req_ready  (request.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_ms     (result.now_ms),
  .res_sec    (result.now_sec),
  .res_minute (result.now_minute),
  .res_hour   (result.now_hour),
  .res_day    (result.now_day),
  .res_month  (result.now_month),
  .res_year   (result.now_year)
);

`default_nettype wire
